@@ hw/rtl/bdq_pkg.sv @@
// bdq_pkg: shared types and constants for the bounded deque.
// Used by bdq_front, bdq_back and bounded_deque; depends on nothing.
package bdq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int VAL_W      = 32;
  localparam int CMD_W      = 3;
  // command queue between front and back; keep a power of two
  localparam int QDEPTH     = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_VIEW       = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_VIEW
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_VIEW
  } back_state_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic                    valid;
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } q_head_t;

  // one result beat
  typedef struct packed {
    logic                    strobe;
    status_t                 status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } res_t;

endpackage

@@ hw/rtl/bdq_ram.sv @@
// bdq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bdq_front.sv @@
// bdq_front: takes commands, decodes them and queues them for the back end.
// Depends on bdq_pkg.
module bdq_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bdq_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [bdq_pkg::VAL_W-1:0]     in_value_in,
  input  logic                                 q_pop,
  output bdq_pkg::q_head_t                     q_head
);
  import bdq_pkg::*;

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } q_entry_t;

  q_entry_t          q_mem_r [QDEPTH];
  logic [QPW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic              accept;
  logic              known;
  logic              push;
  logic              pop;
  op_t               op_dec;

  // decode; reserved codes are swallowed here and never reach the back end
  always_comb begin
    known  = 1'b1;
    op_dec = OP_VIEW;
    case (in_cmd)
      CMD_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      CMD_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      CMD_POP_FRONT:  op_dec = OP_POP_FRONT;
      CMD_POP_BACK:   op_dec = OP_POP_BACK;
      CMD_VIEW:       op_dec = OP_VIEW;
      default:        known  = 1'b0;
    endcase
  end

  assign busy   = (cnt_r == QCW'(QDEPTH));
  assign accept = start && !busy;
  assign push   = accept && known;
  assign pop    = q_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{op: op_dec, value: in_value_in};
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.op    = q_mem_r[rd_ptr_r].op;
  assign q_head.value = q_mem_r[rd_ptr_r].value;

endmodule

@@ hw/rtl/bdq_back.sv @@
// bdq_back: executes queued commands against the ring and forms results.
// Depends on bdq_pkg and bdq_ram.
module bdq_back #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bdq_pkg::q_head_t             q_head,
  output logic                         q_pop,
  output bdq_pkg::res_t                res,
  output logic [$clog2(DEPTH+1)-1:0]   occ
);
  import bdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int SW = OW + 1;

  back_state_t     state_r, state_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;

  logic            strobe_r, strobe_nxt;
  status_t         status_r, status_nxt;
  logic            last_r, last_nxt;
  logic            sel_r, sel_nxt;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [VAL_W-1:0] rdata;

  logic [AW-1:0]   front_dec, front_inc;
  logic [AW-1:0]   pos_tail, pos_last, pos_view;
  logic            full, empty;

  // wrap a sum of a ring index (below DEPTH) and an offset of at most DEPTH
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] d;
    d = s - SW'(DEPTH);
    return (s >= SW'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);
  assign pos_tail  = wrap(SW'(front_r) + SW'(occ_r));
  assign pos_last  = wrap(SW'(front_r) + SW'(occ_r) - SW'(1));
  assign pos_view  = wrap(SW'(front_r) + SW'(idx_r));
  assign full      = (occ_r == OW'(DEPTH));
  assign empty     = (occ_r == '0);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    last_nxt   = 1'b0;
    sel_nxt    = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = pos_tail;
    raddr      = front_r;
    q_pop      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_head.valid) begin
          q_pop      = 1'b1;
          strobe_nxt = 1'b1;
          last_nxt   = 1'b1;
          case (q_head.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                we      = 1'b1;
                occ_nxt = occ_r + OW'(1);
                if (q_head.op == OP_PUSH_FRONT) begin
                  waddr     = front_dec;
                  front_nxt = front_dec;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                re      = 1'b1;
                sel_nxt = 1'b1;
                occ_nxt = occ_r - OW'(1);
                if (q_head.op == OP_POP_FRONT) begin
                  front_nxt = front_inc;
                end else begin
                  raddr = pos_last;
                end
              end
            end
            OP_VIEW: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                re      = 1'b1;
                sel_nxt = 1'b1;
                if (occ_r != OW'(1)) begin
                  last_nxt  = 1'b0;
                  idx_nxt   = AW'(1);
                  state_nxt = BK_VIEW;
                end
              end
            end
            default: begin
              strobe_nxt = 1'b0;
            end
          endcase
        end
      end
      BK_VIEW: begin
        re         = 1'b1;
        raddr      = pos_view;
        sel_nxt    = 1'b1;
        strobe_nxt = 1'b1;
        last_nxt   = (OW'(idx_r) + OW'(1) == occ_r);
        idx_nxt    = idx_r + AW'(1);
        if (last_nxt) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      front_r  <= '0;
      occ_r    <= '0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
      status_r <= ST_OK;
      last_r   <= 1'b0;
      sel_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      occ_r    <= occ_nxt;
      idx_r    <= idx_nxt;
      strobe_r <= strobe_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
      sel_r    <= sel_nxt;
    end
  end

  bdq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_head.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read data lands in the same cycle as the registered beat
  assign res.strobe = strobe_r;
  assign res.status = status_r;
  assign res.value  = sel_r ? signed'(rdata) : '0;
  assign res.last   = last_r;
  assign occ        = occ_r;

endmodule

@@ hw/rtl/bounded_deque.sv @@
// bounded_deque: top level of the double-ended queue of signed 32-bit values.
// Depends on bdq_pkg, bdq_front, bdq_back (and bdq_ram below it).
//
// A command is taken at a rising edge with start high and busy low. Push
// front/back, pop front/back and view act on a ring of DEPTH entries; codes
// 5..7 are accepted and dropped without a result. Every other command gives
// results on out_* for exactly one cycle each, marked by out_strobe, with
// out_last on the final one; the receiver cannot stall them, so it must take
// every strobed beat. The first result of a command passes through the
// command queue and then the result register. A steady stream of pushes
// and pops runs at one command per cycle while no view holds the back end.
// A view holds the back end for one read of the single RAM read port per
// stored entry, or for a single refusal beat when empty; meanwhile the
// two-entry command queue fills and busy rises. Refused pushes (full) and
// refused pops or views (empty) give a single beat with value 0. There is
// no clearing pass: ring entries are only read after they have been pushed.
module bounded_deque #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [bdq_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [bdq_pkg::VAL_W-1:0] in_value_in,
  output logic                             out_strobe,
  output logic [1:0]                       out_status,
  output logic signed [bdq_pkg::VAL_W-1:0] out_value_out,
  output logic                             out_last
);
  import bdq_pkg::*;

  localparam int OW = $clog2(DEPTH + 1);

  q_head_t        q_head;
  logic           q_pop;
  res_t           res;
  logic [OW-1:0]  occ;

  // front: decode and queue
  bdq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_value_in (in_value_in),
    .q_pop       (q_pop),
    .q_head      (q_head)
  );

  // back: ring pointers, storage, result sequencing
  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .res    (res),
    .occ    (occ)
  );

  assign out_strobe    = res.strobe;
  assign out_status    = res.status;
  assign out_value_out = res.value;
  assign out_last      = res.last;

  // fill level never passes the ring size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OW'(DEPTH))
    else $error("occupancy above DEPTH");

  // fill level moves by at most one per cycle
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (occ == $past(occ) || occ == $past(occ) + 1'b1 || occ + 1'b1 == $past(occ)))
    else $error("occupancy jumped");

  // a refusal is always a single, final beat
  a_refuse_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> out_last)
    else $error("refusal without last");

  // a view run has no gaps: a non-final beat is followed by another beat
  a_view_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> out_strobe)
    else $error("gap inside view run");

endmodule
